/* src/ata_pio_disk_device_top_defines.svh */
// Assertion macros for the disk device block.
`ifndef ATA_PIO_DISK_DEVICE_TOP_DEFINES_SVH
`define ATA_PIO_DISK_DEVICE_TOP_DEFINES_SVH

`ifndef SYNTH
`define APDD_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) \
    else $error("apdd assertion failed");
`define APDD_ASSERT_RST(lbl, expr) \
  lbl: assert property (@(posedge clk) expr) \
    else $error("apdd reset assertion failed");
`else
`define APDD_ASSERT(lbl, expr)
`define APDD_ASSERT_RST(lbl, expr)
`endif

`endif

/* src/apdd_pkg.sv */
package apdd_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_NONE  = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_WRITE = 2'd2;
  localparam mode_t MODE_IDENT = 2'd3;

  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;
  localparam logic [7:0] CMD_IDENT = 8'hEC;

  localparam logic [3:0] OFF_DATA   = 4'd0;
  localparam logic [3:0] OFF_ERROR  = 4'd1;
  localparam logic [3:0] OFF_COUNT  = 4'd2;
  localparam logic [3:0] OFF_LBA_LO = 4'd3;
  localparam logic [3:0] OFF_LBA_MD = 4'd4;
  localparam logic [3:0] OFF_LBA_HI = 4'd5;
  localparam logic [3:0] OFF_DRVHD  = 4'd6;
  localparam logic [3:0] OFF_STATUS = 4'd7;
  localparam logic [3:0] OFF_ALTST  = 4'd8;

  localparam logic       REG_CAPACITY = 1'b0;
  localparam logic       REG_PRESENT  = 1'b1;

  localparam logic [15:0] ST_ERR   = 16'h0001;
  localparam logic [15:0] ST_DRQ   = 16'h0008;
  localparam logic [15:0] ERR_ABRT = 16'h0004;

  localparam int unsigned WP_W = 8;
  localparam logic [WP_W-1:0] WP_LAST   = 8'hFF;
  localparam logic [WP_W-1:0] WP_CAP_LO = 8'd60;
  localparam logic [WP_W-1:0] WP_CAP_HI = 8'd61;

  localparam int unsigned CAP_W = 28;
  localparam logic [CAP_W-1:0] CAP_RESET = 28'd64;

endpackage

/* src/ata_pio_disk_device_top.sv */
// ATA master disk behind its task-file registers.
// The in_ channel carries one bus access per transaction: in_tuser says
// read (0) or write (1), and in_tdata holds the register offset and the
// write data. Each transaction yields exactly one out_ transaction with
// the value read, which is zero for writes.
// Register accesses and identify words pass from acceptance straight
// into the output register. A data-port read during a READ transfer
// reads the single-port sector memory, whose read data is registered,
// so that access passes that register and the output register and
// holds off the next one. Throughput is one access per cycle otherwise.
// The output register parts the two sides: a new access is accepted while
// a result waits, provided that result is taken in the same cycle.
// When out_tready is low with a result held, in_tready drops.
// Reset clears the task file, ends any transfer and restores the
// configuration to a capacity of 64 sectors with the drive present.
// Sector memory contents are undefined until written; no clearing pass.
// Configuration writes take effect at the clock edge where cfg_we is high.
module ata_pio_disk_device_top #(
  parameter int unsigned STORE_SECTORS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] register_offset, [19:4] write_data, [23:20] zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] read_data
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [27:0] cfg_wdata
);

  import apdd_pkg::*;

  `include "ata_pio_disk_device_top_defines.svh"

  localparam int unsigned SEC_W  = (STORE_SECTORS > 1) ? $clog2(STORE_SECTORS) : 1;
  localparam int unsigned DEPTH  = STORE_SECTORS * 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [CAP_W-1:0] STORE_LIMIT = CAP_W'(STORE_SECTORS);

  logic [7:0]       lba_lo_r, lba_lo_nxt;
  logic [7:0]       lba_md_r, lba_md_nxt;
  logic [7:0]       lba_hi_r, lba_hi_nxt;
  logic [7:0]       drvhd_r, drvhd_nxt;
  logic [7:0]       count_r, count_nxt;
  logic             err_r, err_nxt;
  logic             drq_r, drq_nxt;
  mode_t            mode_r, mode_nxt;
  logic [WP_W-1:0]  wp_r, wp_nxt;
  logic [SEC_W-1:0] sector_r, sector_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             present_r;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_data_r, out_data_nxt;

  logic             acc;
  logic             wr;
  logic [3:0]       off;
  logic [15:0]      wdata;
  logic [7:0]       lo;
  logic [CAP_W-1:0] lba;
  logic [15:0]      rval;
  logic             ram_we;
  logic             ram_rd;
  logic [ADDR_W-1:0] ram_addr;
  logic [15:0]      ram_rdata;
  logic             advance;

  assign in_tready  = !pend_r && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign wr         = in_tuser;
  assign off        = in_tdata[3:0];
  assign wdata      = in_tdata[19:4];
  assign lo         = wdata[7:0];
  assign lba        = {drvhd_r[3:0], lba_hi_r, lba_md_r, lba_lo_r};
  assign ram_addr   = ADDR_W'({sector_r, wp_r});
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  apdd_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    lba_lo_nxt = lba_lo_r;
    lba_md_nxt = lba_md_r;
    lba_hi_nxt = lba_hi_r;
    drvhd_nxt  = drvhd_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    drq_nxt    = drq_r;
    mode_nxt   = mode_r;
    wp_nxt     = wp_r;
    sector_nxt = sector_r;
    rval       = '0;
    ram_we     = 1'b0;
    ram_rd     = 1'b0;
    advance    = 1'b0;

    if (acc && present_r) begin
      if (!wr) begin
        unique case (off)
          OFF_DATA: begin
            if (drq_r && mode_r == MODE_READ) begin
              ram_rd  = 1'b1;
              advance = 1'b1;
            end else if (drq_r && mode_r == MODE_IDENT) begin
              advance = 1'b1;
              if (wp_r == WP_CAP_LO) begin
                rval = cap_r[15:0];
              end else if (wp_r == WP_CAP_HI) begin
                rval = {4'd0, cap_r[27:16]};
              end
            end
          end
          OFF_ERROR:  rval = err_r ? ERR_ABRT : '0;
          OFF_COUNT:  rval = {8'd0, count_r};
          OFF_LBA_LO: rval = {8'd0, lba_lo_r};
          OFF_LBA_MD: rval = {8'd0, lba_md_r};
          OFF_LBA_HI: rval = {8'd0, lba_hi_r};
          OFF_DRVHD:  rval = {8'd0, drvhd_r};
          OFF_STATUS, OFF_ALTST: rval = (err_r ? ST_ERR : '0) | (drq_r ? ST_DRQ : '0);
          default:    rval = '0;
        endcase
      end else begin
        unique case (off)
          OFF_DATA: begin
            if (drq_r && mode_r == MODE_WRITE) begin
              ram_we  = 1'b1;
              advance = 1'b1;
            end
          end
          OFF_COUNT:  count_nxt  = lo;
          OFF_LBA_LO: lba_lo_nxt = lo;
          OFF_LBA_MD: lba_md_nxt = lo;
          OFF_LBA_HI: lba_hi_nxt = lo;
          OFF_DRVHD:  drvhd_nxt  = lo;
          OFF_STATUS: begin
            drq_nxt  = 1'b0;
            mode_nxt = MODE_NONE;
            wp_nxt   = '0;
            err_nxt  = 1'b0;
            if (drvhd_r[4]) begin
              err_nxt = 1'b1;
            end else if (lo == CMD_READ || lo == CMD_WRITE) begin
              if (lba >= STORE_LIMIT || lba >= cap_r) begin
                err_nxt = 1'b1;
              end else begin
                sector_nxt = lba[SEC_W-1:0];
                mode_nxt   = (lo == CMD_READ) ? MODE_READ : MODE_WRITE;
                drq_nxt    = 1'b1;
              end
            end else if (lo == CMD_IDENT) begin
              mode_nxt = MODE_IDENT;
              drq_nxt  = 1'b1;
            end else if (lo != CMD_FLUSH) begin
              err_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (advance) begin
      if (wp_r == WP_LAST) begin
        drq_nxt  = 1'b0;
        mode_nxt = MODE_NONE;
        wp_nxt   = '0;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end

    pend_nxt = ram_rd;
    priority if (acc && !ram_rd) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rval;
    end else if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = ram_rdata;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_lo_r    <= '0;
      lba_md_r    <= '0;
      lba_hi_r    <= '0;
      drvhd_r     <= '0;
      count_r     <= '0;
      err_r       <= 1'b0;
      drq_r       <= 1'b0;
      mode_r      <= MODE_NONE;
      wp_r        <= '0;
      sector_r    <= '0;
      cap_r       <= CAP_RESET;
      present_r   <= 1'b1;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lba_lo_r    <= lba_lo_nxt;
      lba_md_r    <= lba_md_nxt;
      lba_hi_r    <= lba_hi_nxt;
      drvhd_r     <= drvhd_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      drq_r       <= drq_nxt;
      mode_r      <= mode_nxt;
      wp_r        <= wp_nxt;
      sector_r    <= sector_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_CAPACITY) begin
        cap_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_PRESENT) begin
        present_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `APDD_ASSERT(a_pend_out_free, pend_r |-> !out_valid_r)
  `APDD_ASSERT(a_pend_delivers, pend_r |=> out_valid_r)
  `APDD_ASSERT(a_drq_matches_mode, drq_r == (mode_r != MODE_NONE))
  `APDD_ASSERT(a_store_write_mode, ram_we |-> (drq_r && mode_r == MODE_WRITE))
  `APDD_ASSERT_RST(a_reset_clears, !rst_n |=> (!out_valid_r && !pend_r))

endmodule

/* src/apdd_ram.sv */
module apdd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
